// File: hdl/dcs_pkg.sv
package dcs_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W       =
      ($clog2(MAX_ENTRIES + 1) > 9) ? $clog2(MAX_ENTRIES + 1) : 9;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned RADIUS_W = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DRAW_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned TOTAL_W  = 24;
  localparam int unsigned PROD_W   = DRAW_W + TOTAL_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_APPEND = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_DRAW   = KIND_W'(2);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_BAD_RADIUS,
    OP_DRAW,
    OP_NOP
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_RADIUS = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_THR,
    S_PROBE,
    S_CMP,
    S_FETCH
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [RADIUS_W-1:0] radius;
    logic [WEIGHT_W-1:0] weight;
    logic [DRAW_W-1:0]   draw;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    status_e             status;
    logic [RADIUS_W-1:0] radius;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

// File: hdl/discrete_cdf_sampler_core.sv
// every item but a successful draw goes through the queue and then the result register;
// a successful draw then runs the multiply, threshold, binary search and fetch states,
// the binary search doing one cumulative-sum memory read and one compare per step
// throughput: one item per cycle except successful draws; a 2-entry queue lets start run ahead
// reset clears count, total and queue at once; stored entries are only read below the count
// here the receiver cannot stall: done_o strobes for one cycle per result
module discrete_cdf_sampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dcs_pkg::KIND_W-1:0]    kind_i,
  input  logic [dcs_pkg::RADIUS_W-1:0]  radius_value_i,
  input  logic [dcs_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic [dcs_pkg::DRAW_W-1:0]    uniform_draw_i,
  output logic                          done_o,
  output logic [dcs_pkg::STATUS_W-1:0]  status_o,
  output logic [dcs_pkg::RADIUS_W-1:0]  chosen_radius_o,
  output logic [dcs_pkg::COUNT_W-1:0]   entry_count_o
);

  dcs_pkg::cmd_t    front_cmd;
  dcs_pkg::cmd_t    queue_cmd;
  dcs_pkg::result_t res;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             q_push;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  dcs_front u_front (
    .kind_i         (kind_i),
    .radius_value_i (radius_value_i),
    .weight_i       (weight_i),
    .uniform_draw_i (uniform_draw_i),
    .cmd_o          (front_cmd)
  );

  dcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .cmd_o   (queue_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dcs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (queue_cmd),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .res_o   (res)
  );

  assign done_o          = res.valid;
  assign status_o        = res.status;
  assign chosen_radius_o = res.radius;
  assign entry_count_o   = res.count;

endmodule

// File: hdl/dcs_front.sv
module dcs_front (
  input  logic [dcs_pkg::KIND_W-1:0]   kind_i,
  input  logic [dcs_pkg::RADIUS_W-1:0] radius_value_i,
  input  logic [dcs_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [dcs_pkg::DRAW_W-1:0]   uniform_draw_i,
  output dcs_pkg::cmd_t                cmd_o
);

  // zero radius is rejected here, table state checks are left to the back end
  always_comb begin
    cmd_o.radius = radius_value_i;
    cmd_o.weight = weight_i;
    cmd_o.draw   = uniform_draw_i;
    unique case (kind_i)
      dcs_pkg::KIND_CLEAR:  cmd_o.op = dcs_pkg::OP_CLEAR;
      dcs_pkg::KIND_APPEND: begin
        if (radius_value_i == '0) begin
          cmd_o.op = dcs_pkg::OP_BAD_RADIUS;
        end else begin
          cmd_o.op = dcs_pkg::OP_APPEND;
        end
      end
      dcs_pkg::KIND_DRAW:   cmd_o.op = dcs_pkg::OP_DRAW;
      default:              cmd_o.op = dcs_pkg::OP_NOP;
    endcase
  end

endmodule

// File: hdl/dcs_queue.sv
module dcs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcs_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output dcs_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  dcs_pkg::cmd_t                    entries_q [dcs_pkg::QUEUE_DEPTH];
  logic [dcs_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [dcs_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [dcs_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == dcs_pkg::QCNT_W'(dcs_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == dcs_pkg::QPTR_W'(dcs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dcs_pkg::QPTR_W'(dcs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/dcs_back.sv
module dcs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dcs_pkg::cmd_t    cmd_i,
  input  logic             empty_i,
  output logic             pop_o,
  output dcs_pkg::result_t res_o
);

  dcs_pkg::state_e                  state_q, state_d;
  logic [dcs_pkg::CNT_W-1:0]        held_q, held_d;
  logic [dcs_pkg::TOTAL_W-1:0]      total_q, total_d;
  logic [dcs_pkg::DRAW_W-1:0]       draw_q, draw_d;
  logic [dcs_pkg::PROD_W-1:0]       prod_q, prod_d;
  logic [dcs_pkg::TOTAL_W:0]        thr_q, thr_d;
  logic [dcs_pkg::IDX_W-1:0]        lo_q, lo_d;
  logic [dcs_pkg::IDX_W-1:0]        hi_q, hi_d;
  logic [dcs_pkg::IDX_W-1:0]        mid_q, mid_d;
  dcs_pkg::result_t                 res_q, res_d;

  logic [dcs_pkg::RADIUS_W-1:0]     radius_mem [dcs_pkg::MAX_ENTRIES];
  logic [dcs_pkg::TOTAL_W-1:0]      cum_mem    [dcs_pkg::MAX_ENTRIES];
  logic [dcs_pkg::RADIUS_W-1:0]     rad_rd_q;
  logic [dcs_pkg::TOTAL_W-1:0]      cum_rd_q;

  logic                             table_full;
  logic [dcs_pkg::TOTAL_W:0]        sum_wide;
  logic [dcs_pkg::TOTAL_W-1:0]      sum_sat;
  logic [dcs_pkg::CNT_W-1:0]        held_inc;
  logic [dcs_pkg::CNT_W-1:0]        held_last;
  logic [dcs_pkg::IDX_W:0]          lo_hi_sum;
  logic [dcs_pkg::IDX_W-1:0]        mid;
  logic                             wr_en;
  logic                             cum_rd_en;
  logic                             rad_rd_en;
  logic                             cum_hit;

  assign pop_o      = (state_q == dcs_pkg::S_IDLE) && !empty_i;
  assign table_full = (held_q == dcs_pkg::CNT_W'(dcs_pkg::MAX_ENTRIES));
  assign sum_wide   = {1'b0, total_q} + (dcs_pkg::TOTAL_W + 1)'(cmd_i.weight);
  assign sum_sat    = sum_wide[dcs_pkg::TOTAL_W] ? dcs_pkg::TOTAL_MAX
                                                 : sum_wide[dcs_pkg::TOTAL_W-1:0];
  assign held_inc   = held_q + 1'b1;
  assign held_last  = held_q - 1'b1;
  assign lo_hi_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = lo_hi_sum[dcs_pkg::IDX_W:1];
  assign wr_en      = pop_o && (cmd_i.op == dcs_pkg::OP_APPEND) && !table_full;
  assign cum_rd_en  = (state_q == dcs_pkg::S_PROBE) && (lo_q != hi_q);
  assign rad_rd_en  = (state_q == dcs_pkg::S_PROBE) && (lo_q == hi_q);
  assign cum_hit    = ({1'b0, cum_rd_q} >= thr_q);
  assign res_o      = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcs_pkg::S_IDLE: begin
        if (pop_o && (cmd_i.op == dcs_pkg::OP_DRAW) && (held_q != '0) && (total_q != '0)) begin
          state_d = dcs_pkg::S_MUL;
        end
      end
      dcs_pkg::S_MUL:   state_d = dcs_pkg::S_THR;
      dcs_pkg::S_THR:   state_d = dcs_pkg::S_PROBE;
      dcs_pkg::S_PROBE: state_d = (lo_q == hi_q) ? dcs_pkg::S_FETCH : dcs_pkg::S_CMP;
      dcs_pkg::S_CMP:   state_d = dcs_pkg::S_PROBE;
      dcs_pkg::S_FETCH: state_d = dcs_pkg::S_IDLE;
      default:          state_d = dcs_pkg::S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    held_d       = held_q;
    total_d      = total_q;
    draw_d       = draw_q;
    prod_d       = prod_q;
    thr_d        = thr_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_d        = res_q;
    res_d.valid  = 1'b0;
    unique case (state_q)
      dcs_pkg::S_IDLE: begin
        if (pop_o) begin
          res_d.valid  = 1'b1;
          res_d.status = dcs_pkg::ST_OK;
          res_d.radius = '0;
          res_d.count  = held_q[dcs_pkg::COUNT_W-1:0];
          case (cmd_i.op)
            dcs_pkg::OP_CLEAR: begin
              held_d      = '0;
              total_d     = '0;
              res_d.count = '0;
            end
            dcs_pkg::OP_BAD_RADIUS: begin
              res_d.status = dcs_pkg::ST_BAD_RADIUS;
            end
            dcs_pkg::OP_APPEND: begin
              if (table_full) begin
                res_d.status = dcs_pkg::ST_FULL;
              end else begin
                held_d      = held_inc;
                total_d     = sum_sat;
                res_d.count = held_inc[dcs_pkg::COUNT_W-1:0];
              end
            end
            dcs_pkg::OP_DRAW: begin
              if ((held_q == '0) || (total_q == '0)) begin
                res_d.status = dcs_pkg::ST_EMPTY;
              end else begin
                // result comes out of the search instead
                res_d.valid = 1'b0;
                draw_d      = cmd_i.draw;
                lo_d        = '0;
                hi_d        = held_last[dcs_pkg::IDX_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      dcs_pkg::S_MUL: begin
        prod_d = dcs_pkg::PROD_W'(draw_q) * dcs_pkg::PROD_W'(total_q);
      end
      dcs_pkg::S_THR: begin
        // cum * 2^32 >= prod  <=>  cum >= ceil(prod / 2^32)
        thr_d = {1'b0, prod_q[dcs_pkg::PROD_W-1:dcs_pkg::DRAW_W]}
              + (dcs_pkg::TOTAL_W + 1)'(|prod_q[dcs_pkg::DRAW_W-1:0]);
      end
      dcs_pkg::S_PROBE: begin
        mid_d = mid;
      end
      dcs_pkg::S_CMP: begin
        if (cum_hit) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
      end
      dcs_pkg::S_FETCH: begin
        res_d.valid  = 1'b1;
        res_d.status = dcs_pkg::ST_OK;
        res_d.radius = rad_rd_q;
        res_d.count  = held_q[dcs_pkg::COUNT_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcs_pkg::S_IDLE;
      held_q  <= '0;
      total_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      total_q <= total_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    draw_q       <= draw_d;
    prod_q       <= prod_d;
    thr_q        <= thr_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      radius_mem[held_q[dcs_pkg::IDX_W-1:0]] <= cmd_i.radius;
      cum_mem[held_q[dcs_pkg::IDX_W-1:0]]    <= sum_sat;
    end
    if (cum_rd_en) begin
      cum_rd_q <= cum_mem[mid];
    end
    if (rad_rd_en) begin
      rad_rd_q <= radius_mem[lo_q];
    end
  end

endmodule
